// ===== rtl/packed_dna_mismatch_counter_unit_defines.svh =====
// Assertion macros used by the checker file.
`ifndef PACKED_DNA_MISMATCH_COUNTER_UNIT_DEFINES_SVH
`define PACKED_DNA_MISMATCH_COUNTER_UNIT_DEFINES_SVH

// Property checked only while reset is released.
`define PDMC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Property checked on every edge, reset included.
`define PDMC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/pdmc_pkg.sv =====
`default_nettype none
package pdmc_pkg;

    localparam int WORD_BASES_DEF = 64;
    localparam int REF_WORDS_DEF  = 4096;

    localparam int POS_W      = 18;
    localparam int CNT_W      = 9;
    localparam int CHAR_W     = 8;
    localparam int MAX_W      = 8;
    localparam int RSIZE_W    = 19;
    localparam int WADDR_W    = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;

    localparam logic [MAX_W-1:0]   MAX_MISMATCH_RST = 8'd2;
    localparam logic [RSIZE_W-1:0] REF_SIZE_RST     = 19'd0;
    localparam logic [CHAR_W-1:0]  CHAR_CODE0_RST   = 8'd65;
    localparam logic [CHAR_W-1:0]  CHAR_CODE1_RST   = 8'd67;
    localparam logic [CHAR_W-1:0]  CHAR_CODE2_RST   = 8'd71;
    localparam logic [CHAR_W-1:0]  CHAR_CODE3_RST   = 8'd84;

    typedef enum logic [0:0] {
        OP_WRITE   = 1'b0,
        OP_COMPARE = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_MISMATCH = 3'd0,
        CFG_REF_SIZE     = 3'd1,
        CFG_CHAR_CODE0   = 3'd2,
        CFG_CHAR_CODE1   = 3'd3,
        CFG_CHAR_CODE2   = 3'd4,
        CFG_CHAR_CODE3   = 3'd5
    } t_cfg_idx;

endpackage
`default_nettype wire

// ===== rtl/pdmc_ram.sv =====
`default_nettype none
module pdmc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/packed_dna_mismatch_counter_unit.sv =====
// Packed DNA mismatch counter: one beat per cycle, writes and compares alike.
// A result passes the lookup stage and then the output register before it appears on o_valid.
// Throughput: one input beat per cycle; the input stalls only while a finished
// result sits stalled at the output and a second one is ready behind it.
// Reset (i_rst_n low, synchronous) clears pointer, count, pipeline valids and the
// registers to their defaults; the two base-plane memories stay undefined until written.
`default_nettype none
module packed_dna_mismatch_counter_unit #(
    parameter int WORD_BASES = pdmc_pkg::WORD_BASES_DEF,   // power of two, 8..64
    parameter int REF_WORDS  = pdmc_pkg::REF_WORDS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // input beats
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic                            i_operation,
    input  wire logic [pdmc_pkg::WADDR_W-1:0]    i_word_address,
    input  wire logic [WORD_BASES-1:0]           i_upper_plane,
    input  wire logic [WORD_BASES-1:0]           i_lower_plane,
    input  wire logic [pdmc_pkg::POS_W-1:0]      i_start_position,
    input  wire logic [pdmc_pkg::CHAR_W-1:0]     i_read_char,
    input  wire logic                            i_first_char,
    input  wire logic                            i_last_char,
    // result beats
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic      [pdmc_pkg::CNT_W-1:0]      o_mismatch_count,
    output logic                                 o_exceeded,
    // register writes
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [pdmc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [pdmc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import pdmc_pkg::*;

    localparam int BIT_W  = $clog2(WORD_BASES);
    localparam int AW     = $clog2(REF_WORDS);
    localparam int WIDX_W = POS_W - BIT_W;

    // Configuration registers
    logic [MAX_W-1:0]   r_max;
    logic [RSIZE_W-1:0] r_ref_size;
    logic [CHAR_W-1:0]  r_char [4];

    // Read pointer, advanced as each compare beat is taken
    logic [POS_W-1:0] r_ptr;
    logic             r_past;

    // Lookup stage: memory data arrives here
    logic              r_s1_valid;
    logic              r_s1_first;
    logic              r_s1_last;
    logic              r_s1_oob;
    logic [BIT_W-1:0]  r_s1_bit;
    logic [CHAR_W-1:0] r_s1_char;

    logic [CNT_W-1:0] r_count;

    // Output register
    logic             r_out_valid;
    logic [CNT_W-1:0] r_out_count;
    logic             r_out_exceeded;

    logic              s1_hold;
    logic              adv;
    logic              in_acc;
    logic              cmp_acc;
    logic              wr_acc;
    logic [POS_W-1:0]  n_pos;
    logic              n_past;
    logic [POS_W-1:0]  n_ptr;
    logic [WIDX_W-1:0] word_idx;
    logic [31:0]       word_idx32;
    logic [31:0]       waddr32;
    logic              n_oob;
    logic [AW-1:0]     ram_raddr;
    logic [AW-1:0]     ram_waddr;
    logic              ram_we;
    logic [WORD_BASES-1:0] upper_rdata;
    logic [WORD_BASES-1:0] lower_rdata;
    logic [1:0]        code;
    logic              mismatch;
    logic [CNT_W-1:0]  base_count;
    logic [CNT_W-1:0]  n_count;
    logic              n_exceeded;
    logic              n_out_valid;

    // Hold the whole pipe only when a second result waits behind a stalled one.
    assign s1_hold = r_s1_valid && r_s1_last && r_out_valid && i_stall;
    assign adv     = !s1_hold;
    assign o_stall = s1_hold;

    assign in_acc  = i_valid && adv;
    assign cmp_acc = in_acc && (t_op'(i_operation) == OP_COMPARE);
    assign wr_acc  = in_acc && (t_op'(i_operation) == OP_WRITE);

    // Position of this character: restart on the first one of a read.
    assign n_pos  = i_first_char ? i_start_position : r_ptr;
    assign n_past = i_first_char ? 1'b0 : r_past;
    assign n_ptr  = n_pos + POS_W'(1);

    assign word_idx   = n_pos[POS_W-1:BIT_W];
    assign word_idx32 = 32'(word_idx);
    assign waddr32    = 32'(i_word_address);

    // Out-of-range bases count as mismatches; the memory data is ignored then.
    assign n_oob = n_past || ({1'b0, n_pos} >= r_ref_size) ||
                   (word_idx32 >= 32'(REF_WORDS));

    assign ram_raddr = word_idx32[AW-1:0];
    assign ram_waddr = waddr32[AW-1:0];
    assign ram_we    = wr_acc && (waddr32 < 32'(REF_WORDS));

    pdmc_ram #(
        .WIDTH (WORD_BASES),
        .DEPTH (REF_WORDS)
    ) u_upper_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_upper_plane),
        .i_re    (adv),
        .i_raddr (ram_raddr),
        .o_rdata (upper_rdata)
    );

    pdmc_ram #(
        .WIDTH (WORD_BASES),
        .DEPTH (REF_WORDS)
    ) u_lower_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_lower_plane),
        .i_re    (adv),
        .i_raddr (ram_raddr),
        .o_rdata (lower_rdata)
    );

    // Compare and count, one character per cycle while the pipe is not held.
    always_comb begin
        code       = {upper_rdata[r_s1_bit], lower_rdata[r_s1_bit]};
        mismatch   = r_s1_oob || (r_s1_char != r_char[code]);
        base_count = r_s1_first ? '0 : r_count;
        n_count    = base_count;
        // saturate at max_mismatch + 1
        if (mismatch && (base_count <= {1'b0, r_max})) begin
            n_count = base_count + CNT_W'(1);
        end
        n_exceeded = n_count > {1'b0, r_max};
    end

    always_comb begin
        n_out_valid = r_out_valid && i_stall;
        if (adv && r_s1_valid && r_s1_last) begin
            n_out_valid = 1'b1;
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max      <= MAX_MISMATCH_RST;
            r_ref_size <= REF_SIZE_RST;
            r_char[0]  <= CHAR_CODE0_RST;
            r_char[1]  <= CHAR_CODE1_RST;
            r_char[2]  <= CHAR_CODE2_RST;
            r_char[3]  <= CHAR_CODE3_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MAX_MISMATCH: r_max      <= i_cfg_data[MAX_W-1:0];
                CFG_REF_SIZE:     r_ref_size <= i_cfg_data[RSIZE_W-1:0];
                CFG_CHAR_CODE0:   r_char[0]  <= i_cfg_data[CHAR_W-1:0];
                CFG_CHAR_CODE1:   r_char[1]  <= i_cfg_data[CHAR_W-1:0];
                CFG_CHAR_CODE2:   r_char[2]  <= i_cfg_data[CHAR_W-1:0];
                CFG_CHAR_CODE3:   r_char[3]  <= i_cfg_data[CHAR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr       <= '0;
            r_past      <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (cmp_acc) begin
                r_ptr  <= n_ptr;
                // flag a wrap past the top of the position range
                r_past <= n_past || (n_ptr == '0);
            end
            if (adv) begin
                r_s1_valid <= cmp_acc;
            end
            if (adv && r_s1_valid) begin
                r_count <= n_count;
            end
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmp_acc) begin
            r_s1_first <= i_first_char;
            r_s1_last  <= i_last_char;
            r_s1_oob   <= n_oob;
            r_s1_bit   <= n_pos[BIT_W-1:0];
            r_s1_char  <= i_read_char;
        end
        if (adv && r_s1_valid && r_s1_last) begin
            r_out_count    <= n_count;
            r_out_exceeded <= n_exceeded;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_mismatch_count = r_out_count;
    assign o_exceeded       = r_out_exceeded;

endmodule
`default_nettype wire

// ===== rtl/pdmc_checker.sv =====
`default_nettype none
`include "packed_dna_mismatch_counter_unit_defines.svh"
module pdmc_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_valid,
    input wire logic                       o_stall,
    input wire logic                       o_valid,
    input wire logic                       i_stall,
    input wire logic [pdmc_pkg::CNT_W-1:0] o_mismatch_count,
    input wire logic                       o_exceeded
);
    import pdmc_pkg::*;

    // A stalled result holds its value.
    `PDMC_ASSERT(a_out_hold, o_valid && i_stall |=> o_valid && $stable(o_mismatch_count) && $stable(o_exceeded), "stalled result changed")

    // Exceeding the limit needs at least one mismatch.
    `PDMC_ASSERT(a_exceeded_nonzero, o_valid && o_exceeded |-> o_mismatch_count != '0, "exceeded with zero count")

    // Below the limit the count fits under the largest limit.
    `PDMC_ASSERT(a_within_limit, o_valid && !o_exceeded |-> !o_mismatch_count[CNT_W-1], "count above any limit not flagged")

    // Input backpressure only while a result is held at the output.
    `PDMC_ASSERT(a_stall_cause, o_stall |-> o_valid && i_stall, "input stalled without output backpressure")

    `PDMC_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> !o_valid, "result valid after reset")

endmodule

bind packed_dna_mismatch_counter_unit pdmc_checker u_pdmc_checker (.*);
`default_nettype wire

// ===== tb/packed_dna_mismatch_counter_unit_tb.sv =====
`timescale 1ns / 100ps

module packed_dna_mismatch_counter_unit_tb;
    import pdmc_pkg::*;

    localparam int          HOLD_CYCLES = 300;     // long receiver hold-off
    localparam int          CYCLE_LIMIT = 200000;  // watchdog
    localparam int          SLOT_BEATS  = 95;      // random beats per register setting
    localparam int          DRAIN_WAIT  = 8;       // idle wait after the last tally arrives
    localparam logic [POS_W-1:0] POS_TOP = {POS_W{1'b1}};

    // One input beat: a reference word write or one read character.
    typedef struct {
        t_op                op;
        logic [WADDR_W-1:0] addr;
        logic [63:0]        upper;
        logic [63:0]        lower;
        logic [POS_W-1:0]   start;
        logic [CHAR_W-1:0]  ch;
        logic               first;
        logic               last;
    } t_dna_beat;

    // One result beat: the mismatch tally of a finished read.
    typedef struct {
        logic [CNT_W-1:0] count;
        logic             exceeded;
    } t_tally;

    // Mirrors the reference planes, read pointer, running count and registers,
    // and keeps the tallies that reads have finished but the block has not yet
    // delivered.
    class tally_scoreboard;
        logic [63:0]       upper_words [REF_WORDS_DEF];
        logic [63:0]       lower_words [REF_WORDS_DEF];
        bit                written     [REF_WORDS_DEF];
        logic [CNT_W-1:0]  count;
        logic [POS_W-1:0]  ptr;
        bit                wrapped;
        logic [MAX_W-1:0]  max_mm;
        logic [RSIZE_W-1:0] ref_size;
        logic [CHAR_W-1:0] code_char [4];
        t_tally            pending [$];
        int                errors;
        int                n_writes;
        int                n_chars;
        int                n_checked;

        function new();
            count        = '0;
            ptr          = '0;
            wrapped      = 1'b0;
            max_mm       = MAX_MISMATCH_RST;
            ref_size     = REF_SIZE_RST;
            code_char[0] = CHAR_CODE0_RST;
            code_char[1] = CHAR_CODE1_RST;
            code_char[2] = CHAR_CODE2_RST;
            code_char[3] = CHAR_CODE3_RST;
            errors       = 0;
            n_writes     = 0;
            n_chars      = 0;
            n_checked    = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_MAX_MISMATCH: max_mm       = val[MAX_W-1:0];
                CFG_REF_SIZE:     ref_size     = val[RSIZE_W-1:0];
                CFG_CHAR_CODE0:   code_char[0] = val[CHAR_W-1:0];
                CFG_CHAR_CODE1:   code_char[1] = val[CHAR_W-1:0];
                CFG_CHAR_CODE2:   code_char[2] = val[CHAR_W-1:0];
                CFG_CHAR_CODE3:   code_char[3] = val[CHAR_W-1:0];
                default: ;
            endcase
        endfunction

        // Base p sits in word p / 64 at bit p % 64; code = {upper, lower}.
        function logic [CHAR_W-1:0] base_char(logic [POS_W-1:0] pos);
            logic [1:0] code;
            code = {upper_words[pos[POS_W-1:6]][pos[5:0]],
                    lower_words[pos[POS_W-1:6]][pos[5:0]]};
            return code_char[code];
        endfunction

        // Bases past ref_size or after a pointer wrap count as mismatches
        // without touching the planes.
        function bit no_store_read(logic [POS_W-1:0] pos, bit wr);
            return wr || (pos >= ref_size);
        endfunction

        function void absorb_beat(t_dna_beat b);
            bit     miss;
            t_tally t;
            if (b.op == OP_WRITE) begin
                upper_words[b.addr] = b.upper;
                lower_words[b.addr] = b.lower;
                written[b.addr]     = 1'b1;
                n_writes++;
                return;
            end
            n_chars++;
            if (b.first) begin
                ptr     = b.start;
                count   = '0;
                wrapped = 1'b0;
            end
            miss = no_store_read(ptr, wrapped) ? 1'b1 : (b.ch != base_char(ptr));
            // counting stops one past the tolerated limit
            if (miss && count <= max_mm)
                count = count + 1'b1;
            ptr = ptr + 1'b1;
            if (ptr == '0)
                wrapped = 1'b1;
            if (b.last) begin
                t.count    = count;
                t.exceeded = (count > max_mm);
                pending.push_back(t);
            end
        endfunction

        function void check_tally(logic [CNT_W-1:0] cnt, logic exc);
            t_tally want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("Unexpected result beat: count %0d exceeded %0b", cnt, exc);
                return;
            end
            want = pending.pop_front();
            n_checked++;
            if (cnt !== want.count) begin
                errors++;
                if (errors <= 10)
                    $display("Result %0d mismatch_count: expected %0d, got %0d",
                             n_checked, want.count, cnt);
            end
            if (exc !== want.exceeded) begin
                errors++;
                if (errors <= 10)
                    $display("Result %0d exceeded: expected %0b, got %0b",
                             n_checked, want.exceeded, exc);
            end
        endfunction
    endclass

    tally_scoreboard sb = new();

    // Block ports; the inputs are at known values from time zero.
    logic                  i_clk            = 1'b0;
    logic                  i_rst_n          = 1'b0;
    logic                  i_valid          = 1'b0;
    logic                  o_stall;
    logic                  i_operation      = 1'b0;
    logic [WADDR_W-1:0]    i_word_address   = '0;
    logic [63:0]           i_upper_plane    = '0;
    logic [63:0]           i_lower_plane    = '0;
    logic [POS_W-1:0]      i_start_position = '0;
    logic [CHAR_W-1:0]     i_read_char      = '0;
    logic                  i_first_char     = 1'b0;
    logic                  i_last_char      = 1'b0;
    logic                  o_valid;
    logic                  i_stall          = 1'b0;
    logic [CNT_W-1:0]      o_mismatch_count;
    logic                  o_exceeded;
    logic                  i_cfg_valid      = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index      = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data       = '0;

    int tx_idle_pct      = 0;   // owned by the stimulus process
    int rx_idle_pct      = 0;   // written by the stimulus process, read by the stall process
    int hold_requests    = 0;   // bumped to ask the stall process for a hold-off
    int hold_seen        = 0;
    int hold_left        = 0;
    int cycles           = 0;
    int beats            = 0;
    int settings_applied = 0;

    packed_dna_mismatch_counter_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_operation      (i_operation),
        .i_word_address   (i_word_address),
        .i_upper_plane    (i_upper_plane),
        .i_lower_plane    (i_lower_plane),
        .i_start_position (i_start_position),
        .i_read_char      (i_read_char),
        .i_first_char     (i_first_char),
        .i_last_char      (i_last_char),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_mismatch_count (o_mismatch_count),
        .o_exceeded       (o_exceeded),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog: end the run if it hangs.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver stall: a requested hold-off first, random stalls otherwise.
    always @(posedge i_clk) begin
        if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // Result monitor: check every accepted result beat against the oldest tally.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_tally(o_mismatch_count, o_exceeded);
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [POS_W-1:0] rand_pos();
        return POS_W'($urandom);
    endfunction

    // Fill the unused high bits of a narrow register write with noise.
    function automatic logic [CFG_DATA_W-1:0] pad(logic [7:0] v);
        return CFG_DATA_W'({$urandom, v});
    endfunction

    // Fields a write does not use carry noise so every input bit toggles.
    function automatic t_dna_beat word_beat(logic [WADDR_W-1:0] addr, logic [63:0] up,
                                            logic [63:0] lo);
        t_dna_beat b;
        b.op    = OP_WRITE;
        b.addr  = addr;
        b.upper = up;
        b.lower = lo;
        b.start = rand_pos();
        b.ch    = CHAR_W'($urandom);
        b.first = 1'($urandom_range(0, 1));
        b.last  = 1'($urandom_range(0, 1));
        return b;
    endfunction

    function automatic t_dna_beat char_beat(logic [POS_W-1:0] start, logic [CHAR_W-1:0] ch,
                                            logic first, logic last);
        t_dna_beat b;
        b.op    = OP_COMPARE;
        b.addr  = WADDR_W'($urandom);
        b.upper = rand64();
        b.lower = rand64();
        b.start = start;
        b.ch    = ch;
        b.first = first;
        b.last  = last;
        return b;
    endfunction

    // A base is safe to compare if it never reads the planes or its word is loaded.
    function automatic bit base_safe(logic [POS_W-1:0] p, bit w);
        return sb.no_store_read(p, w) || sb.written[p[POS_W-1:6]];
    endfunction

    // Matching character most of the time, noise with probability err percent.
    function automatic logic [CHAR_W-1:0] pick_char(logic [POS_W-1:0] p, bit w, int err);
        if (sb.no_store_read(p, w) || $urandom_range(99) < err)
            return CHAR_W'($urandom);
        return sb.base_char(p);
    endfunction

    function automatic logic [POS_W-1:0] pick_start(int win_lo, int span);
        int               r;
        int               t;
        logic [POS_W-1:0] s;
        r = $urandom_range(99);
        if (r < 70) begin
            s = POS_W'(win_lo + $urandom_range(0, span - 1));
        end else if (r < 85) begin
            s = rand_pos();
        end else if (r < 93 && sb.ref_size > 0) begin
            // straddle the end of the loaded reference
            t = int'(sb.ref_size) - int'($urandom_range(1, 20));
            s = (t < 0) ? '0 : POS_W'(t);
        end else begin
            // run off the top of the pointer range
            s = POS_TOP - POS_W'($urandom_range(0, 12));
        end
        if (!base_safe(s, 1'b0))
            s = POS_W'(win_lo);
        return s;
    endfunction

    // Offer one beat, with an optional idle gap first; hold it until taken.
    task automatic send_beat(t_dna_beat b);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_operation      <= b.op;
        i_word_address   <= b.addr;
        i_upper_plane    <= b.upper;
        i_lower_plane    <= b.lower;
        i_start_position <= b.start;
        i_read_char      <= b.ch;
        i_first_char     <= b.first;
        i_last_char      <= b.last;
        do @(posedge i_clk); while (o_stall);
        sb.absorb_beat(b);
        beats++;
    endtask

    // Stream a read from start; cut it short before any base in an unloaded word.
    task automatic send_read(logic [POS_W-1:0] start, int len, int err, bit close);
        logic [POS_W-1:0] p;
        bit               w;
        int               n;
        int               k;
        p = start;
        w = 1'b0;
        n = 0;
        while (n < len && base_safe(p, w)) begin
            n++;
            p = p + 1'b1;
            if (p == '0)
                w = 1'b1;
        end
        p = start;
        w = 1'b0;
        for (k = 0; k < n; k++) begin
            send_beat(char_beat((k == 0) ? start : rand_pos(), pick_char(p, w, err),
                                k == 0, close && k == n - 1));
            p = p + 1'b1;
            if (p == '0)
                w = 1'b1;
        end
    endtask

    // Continue the current read from where the block's pointer stands.
    task automatic send_tail(int n, int err, bit close);
        int k;
        for (k = 0; k < n; k++) begin
            if (!base_safe(sb.ptr, sb.wrapped))
                return;
            send_beat(char_beat(rand_pos(), pick_char(sb.ptr, sb.wrapped, err), 1'b0,
                                close && k == n - 1));
        end
    endtask

    // Drop valid, wait for every tally to arrive, then let the pipe go quiet.
    task automatic settle();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, val);
    endtask

    task automatic apply_settings(logic [7:0] mm, logic [RSIZE_W-1:0] rs, logic [7:0] c0,
                                  logic [7:0] c1, logic [7:0] c2, logic [7:0] c3);
        write_reg(CFG_MAX_MISMATCH, pad(mm));
        write_reg(CFG_REF_SIZE, rs);
        write_reg(CFG_CHAR_CODE0, pad(c0));
        write_reg(CFG_CHAR_CODE1, pad(c1));
        write_reg(CFG_CHAR_CODE2, pad(c2));
        write_reg(CFG_CHAR_CODE3, pad(c3));
        i_cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    // One register setting: load a window of reference words, then stream
    // mostly well-formed reads into it, mixed with stray characters, abandoned
    // reads and writes to random words.
    task automatic run_slot(int n, bit pressure);
        int         nw;
        int         wb;
        int         win_lo;
        int         span;
        int         rs;
        int         r;
        int         len;
        int         err;
        int         stop_at;
        logic [7:0] mm;
        logic [7:0] c [4];
        settle();
        nw = $urandom_range(1, 6);
        case (n % 3)
            0:       wb = 0;
            1:       wb = REF_WORDS_DEF - nw;
            default: wb = $urandom_range(0, REF_WORDS_DEF - nw);
        endcase
        win_lo = wb * 64;
        span   = nw * 64;
        case (n % 4)
            0:       mm = 8'd0;
            1:       mm = 8'd255;
            2:       mm = 8'($urandom_range(1, 6));
            default: mm = 8'($urandom_range(0, 255));
        endcase
        if (n == 0) begin
            rs = 262144;
        end else if (n == 1) begin
            rs = 0;
        end else begin
            case ($urandom_range(0, 2))
                0:       rs = 262144;
                1:       rs = win_lo + $urandom_range(0, span);
                default: rs = $urandom_range(0, 262144);
            endcase
        end
        case (n % 3)
            0: begin
                c[0] = 8'd65; c[1] = 8'd67; c[2] = 8'd71; c[3] = 8'd84;
            end
            1: begin
                c[0] = 8'h00; c[1] = 8'hFF; c[2] = 8'($urandom); c[3] = 8'($urandom);
            end
            default: begin
                c[0] = 8'($urandom); c[1] = 8'($urandom);
                c[2] = 8'($urandom); c[3] = 8'($urandom);
            end
        endcase
        apply_settings(mm, RSIZE_W'(rs), c[0], c[1], c[2], c[3]);
        for (r = 0; r < nw; r++)
            send_beat(word_beat(WADDR_W'(wb + r), rand64(), rand64()));
        // With ref_size zero every base misses: drive the count to saturation.
        if (rs == 0)
            send_read(rand_pos(), 260, 100, 1'b1);
        if (pressure) begin
            // Hold the receiver off while single-character reads keep coming,
            // so finished tallies back up and the block stalls its input.
            hold_requests <= hold_requests + 1;
            repeat (40) send_read(pick_start(win_lo, span), 1, 30, 1'b1);
        end
        stop_at = beats + SLOT_BEATS;
        while (beats < stop_at) begin
            r = $urandom_range(99);
            case ($urandom_range(0, 3))
                0:       err = 0;
                1:       err = 5;
                2:       err = 20;
                default: err = 60;
            endcase
            if (r < 8) begin
                send_beat(word_beat(WADDR_W'($urandom), rand64(), rand64()));
            end else if (r < 14) begin
                send_tail($urandom_range(1, 3), err, 1'($urandom_range(0, 1)));
            end else if (r < 20) begin
                send_read(pick_start(win_lo, span), $urandom_range(1, 10), err, 1'b0);
            end else begin
                r = $urandom_range(99);
                if (r < 70)
                    len = $urandom_range(1, 10);
                else if (r < 95)
                    len = $urandom_range(11, 40);
                else
                    len = $urandom_range(41, 90);
                send_read(pick_start(win_lo, span), len, err, 1'b1);
            end
        end
    endtask

    initial begin
        int phase;
        int slot;

        tx_idle_pct = 37;
        rx_idle_pct <= 61;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Straight after reset: no first character, so the read starts at
        // base zero with a zero count; ref_size is zero, so both bases miss.
        send_beat(char_beat(rand_pos(), 8'h41, 1'b0, 1'b0));
        send_beat(char_beat(rand_pos(), 8'hFF, 1'b0, 1'b1));
        settle();

        apply_settings(8'd2, 19'd262144, 8'd65, 8'd67, 8'd71, 8'd84);
        send_beat(word_beat(12'd0, '1, '0));
        send_beat(word_beat(12'd1, '0, '1));
        send_beat(word_beat(12'd2, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210));
        send_beat(word_beat(12'd4095, 64'hFFFF_FFFF_0000_0000, 64'hAAAA_AAAA_AAAA_AAAA));
        send_read(18'd5, 1, 0, 1'b1);          // first and last on one character
        send_read(18'd61, 6, 0, 1'b1);         // crosses a word boundary
        send_read(POS_TOP - 1'b1, 3, 0, 1'b1); // wraps the pointer: the last base misses
        send_read(POS_TOP, 1, 100, 1'b1);
        send_read(18'd128, 6, 100, 1'b1);      // count saturates one past the limit

        // Change the limit in the middle of a read, then finish it.
        send_beat(char_beat(18'd130, 8'h00, 1'b1, 1'b0));
        send_beat(char_beat(rand_pos(), 8'hFF, 1'b0, 1'b0));
        settle();
        write_reg(CFG_MAX_MISMATCH, pad(8'd0));
        i_cfg_valid <= 1'b0;
        send_tail(1, 0, 1'b1);

        // Random part: receiver-heavy idling, sender-heavy idling, then none.
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 37;
                    rx_idle_pct <= 61;
                end
                1: begin
                    tx_idle_pct = 61;
                    rx_idle_pct <= 37;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct <= 0;
                end
            endcase
            for (slot = 0; slot < 3; slot++)
                run_slot(phase * 3 + slot, phase == 2 && slot == 1);
        end

        settle();
        sb.errors += sb.pending.size();

        $display("Covered %0d input beats (%0d word writes, %0d read characters), %0d results",
                 beats, sb.n_writes, sb.n_chars, sb.n_checked);
        $display("checked over %0d register settings, %0d cycles, %0d failures",
                 settings_applied, cycles, sb.errors);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/pdmc_pkg.sv
rtl/pdmc_ram.sv
rtl/packed_dna_mismatch_counter_unit.sv
rtl/pdmc_checker.sv
tb/packed_dna_mismatch_counter_unit_tb.sv
